// File: rtl/core/array_linked_list_engine_defines.svh
// assertion macros for the array linked list engine
`ifndef ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LINKED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define ALE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ALE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ALE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define ALE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// File: rtl/core/ale_pkg.sv
// shared types, codes and microcode table of the array linked list engine
package ale_pkg;

	localparam int NODE_COUNT = 8;
	localparam int ADDR_W = $clog2(NODE_COUNT);
	localparam int IDX_W = $clog2(NODE_COUNT + 1);
	localparam int VAL_W = 32;
	localparam int CMD_W = 3;
	localparam int ST_W = 3;
	localparam int UPC_W = 5;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [UPC_W-1:0] upc_t;

	localparam idx_t NIL = idx_t'(NODE_COUNT);
	localparam idx_t WALK_MAX = idx_t'(NODE_COUNT);
	localparam idx_t TAIL_MAX = idx_t'(NODE_COUNT - 1);

	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_AFTER = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_AFTER = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd5;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd1;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd2;
	localparam logic [ST_W-1:0] ST_MISSING = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTHING_AFTER = 3'd4;

	// sequencer ops
	localparam logic [2:0] OP_NEXT = 3'd0;
	localparam logic [2:0] OP_GOTO = 3'd1;
	localparam logic [2:0] OP_BRANCH = 3'd2;
	localparam logic [2:0] OP_WAIT = 3'd3;
	localparam logic [2:0] OP_DISPATCH = 3'd4;

	// condition select
	localparam logic [3:0] C_NO_ACCEPT = 4'd0;
	localparam logic [3:0] C_FREE_NIL = 4'd1;
	localparam logic [3:0] C_SEARCH_END = 4'd2;
	localparam logic [3:0] C_NO_MATCH = 4'd3;
	localparam logic [3:0] C_P_NIL = 4'd4;
	localparam logic [3:0] C_TAIL_END = 4'd5;
	localparam logic [3:0] C_LRD_VALID = 4'd6;
	localparam logic [3:0] C_CMD_DEL = 4'd7;
	localparam logic [3:0] C_PREV_NIL = 4'd8;
	localparam logic [3:0] C_OUT_BUSY = 4'd9;

	// read address select
	localparam logic [1:0] RA_NONE = 2'd0;
	localparam logic [1:0] RA_FREE = 2'd1;
	localparam logic [1:0] RA_P = 2'd2;
	localparam logic [1:0] RA_HEAD = 2'd3;

	// link write: node <- data
	localparam logic [3:0] LW_NONE = 4'd0;
	localparam logic [3:0] LW_N_HEAD = 4'd1;
	localparam logic [3:0] LW_N_P = 4'd2;
	localparam logic [3:0] LW_Q_N = 4'd3;
	localparam logic [3:0] LW_Q_LRD = 4'd4;
	localparam logic [3:0] LW_N_FREE = 4'd5;
	localparam logic [3:0] LW_N_NIL = 4'd6;
	localparam logic [3:0] LW_P_N = 4'd7;
	localparam logic [3:0] LW_Q_NIL = 4'd8;
	localparam logic [3:0] LW_P_FREE = 4'd9;

	localparam logic [1:0] N_NONE = 2'd0;
	localparam logic [1:0] N_FREE = 2'd1;
	localparam logic [1:0] N_P = 2'd2;
	localparam logic [1:0] N_HEAD = 2'd3;

	localparam logic [1:0] F_NONE = 2'd0;
	localparam logic [1:0] F_LRD = 2'd1;
	localparam logic [1:0] F_N = 2'd2;
	localparam logic [1:0] F_P = 2'd3;

	localparam logic [1:0] H_NONE = 2'd0;
	localparam logic [1:0] H_N = 2'd1;
	localparam logic [1:0] H_LRD = 2'd2;
	localparam logic [1:0] H_NIL = 2'd3;

	localparam logic [1:0] W_NONE = 2'd0;
	localparam logic [1:0] W_ADV = 2'd1;
	localparam logic [1:0] W_STEP = 2'd2;

	// microprogram steps
	localparam upc_t S_IDLE = 5'd0;
	localparam upc_t S_DISP = 5'd1;
	localparam upc_t S_IH0 = 5'd2;
	localparam upc_t S_IH1 = 5'd3;
	localparam upc_t S_SR0 = 5'd4;
	localparam upc_t S_SR1 = 5'd5;
	localparam upc_t S_FND = 5'd6;
	localparam upc_t S_IA0 = 5'd7;
	localparam upc_t S_IA1 = 5'd8;
	localparam upc_t S_IA2 = 5'd9;
	localparam upc_t S_DA0 = 5'd10;
	localparam upc_t S_DA1 = 5'd11;
	localparam upc_t S_DA2 = 5'd12;
	localparam upc_t S_IT0 = 5'd13;
	localparam upc_t S_IT1 = 5'd14;
	localparam upc_t S_TW0 = 5'd15;
	localparam upc_t S_TW1 = 5'd16;
	localparam upc_t S_TX = 5'd17;
	localparam upc_t S_IT2 = 5'd18;
	localparam upc_t S_DT0 = 5'd19;
	localparam upc_t S_DT1 = 5'd20;
	localparam upc_t S_DT2 = 5'd21;
	localparam upc_t S_DT2B = 5'd22;
	localparam upc_t S_DT3 = 5'd23;
	localparam upc_t S_DH0 = 5'd24;
	localparam upc_t S_DH1 = 5'd25;
	localparam upc_t S_OVF = 5'd26;
	localparam upc_t S_UND = 5'd27;
	localparam upc_t S_MIS = 5'd28;
	localparam upc_t S_NAF = 5'd29;
	localparam upc_t S_DONE = 5'd30;

	typedef struct packed {
		logic in_rdy;
		logic [2:0] seq_op;
		logic [3:0] csel;
		upc_t target;
		logic [1:0] rd_sel;
		logic [3:0] lw_sel;
		logic vw;
		logic [1:0] n_sel;
		logic [1:0] f_sel;
		logic [1:0] h_sel;
		logic [1:0] walk;
		logic rm_ld;
		logic st_ld;
		logic [ST_W-1:0] st_code;
		logic out_ld;
	} ctl_t;

	typedef struct packed {
		logic accept;
		logic empty;
		logic [CMD_W-1:0] cmd;
		logic free_nil;
		logic search_end;
		logic no_match;
		logic p_nil;
		logic tail_end;
		logic lrd_valid;
		logic cmd_del;
		logic prev_nil;
		logic out_busy;
	} cond_t;

	function automatic logic is_valid(input idx_t i);
		return i < NIL;
	endfunction

	function automatic upc_t dispatch(input logic [CMD_W-1:0] cmd, input logic empty);
		upc_t s;
		case (cmd)
			CMD_INS_HEAD: s = S_IH0;
			CMD_INS_AFTER: s = empty ? S_IH0 : S_SR0;
			CMD_INS_TAIL: s = empty ? S_IH0 : S_IT0;
			CMD_DEL_HEAD: s = empty ? S_UND : S_DH0;
			CMD_DEL_AFTER: s = empty ? S_UND : S_SR0;
			CMD_DEL_TAIL: s = empty ? S_UND : S_TW0;
			default: s = S_DONE;
		endcase
		return s;
	endfunction

	function automatic ctl_t ucode(input upc_t step);
		ctl_t w;
		w = '0;
		case (step)
			S_IDLE: begin
				w.in_rdy = 1'b1;
				w.seq_op = OP_WAIT;
				w.csel = C_NO_ACCEPT;
				w.target = S_DISP;
			end
			S_DISP: begin
				w.seq_op = OP_DISPATCH;
			end
			S_IH0: begin
				w.rd_sel = RA_FREE;
				w.n_sel = N_FREE;
				w.seq_op = OP_BRANCH;
				w.csel = C_FREE_NIL;
				w.target = S_OVF;
			end
			S_IH1: begin
				w.f_sel = F_LRD;
				w.vw = 1'b1;
				w.lw_sel = LW_N_HEAD;
				w.h_sel = H_N;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_SR0: begin
				w.rd_sel = RA_P;
				w.seq_op = OP_BRANCH;
				w.csel = C_SEARCH_END;
				w.target = S_MIS;
			end
			S_SR1: begin
				w.walk = W_ADV;
				w.seq_op = OP_BRANCH;
				w.csel = C_NO_MATCH;
				w.target = S_SR0;
			end
			S_FND: begin
				w.seq_op = OP_BRANCH;
				w.csel = C_CMD_DEL;
				w.target = S_DA0;
			end
			S_IA0: begin
				w.rd_sel = RA_FREE;
				w.n_sel = N_FREE;
				w.seq_op = OP_BRANCH;
				w.csel = C_FREE_NIL;
				w.target = S_OVF;
			end
			S_IA1: begin
				w.f_sel = F_LRD;
				w.vw = 1'b1;
				w.lw_sel = LW_N_P;
			end
			S_IA2: begin
				w.lw_sel = LW_Q_N;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_DA0: begin
				w.rd_sel = RA_P;
				w.n_sel = N_P;
				w.seq_op = OP_BRANCH;
				w.csel = C_P_NIL;
				w.target = S_NAF;
			end
			S_DA1: begin
				w.rm_ld = 1'b1;
				w.lw_sel = LW_Q_LRD;
			end
			S_DA2: begin
				w.lw_sel = LW_N_FREE;
				w.f_sel = F_N;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_IT0: begin
				w.rd_sel = RA_FREE;
				w.n_sel = N_FREE;
				w.seq_op = OP_BRANCH;
				w.csel = C_FREE_NIL;
				w.target = S_OVF;
			end
			S_IT1: begin
				w.f_sel = F_LRD;
				w.vw = 1'b1;
				w.lw_sel = LW_N_NIL;
			end
			S_TW0: begin
				w.rd_sel = RA_P;
				w.seq_op = OP_BRANCH;
				w.csel = C_TAIL_END;
				w.target = S_TX;
			end
			S_TW1: begin
				w.walk = W_STEP;
				w.seq_op = OP_BRANCH;
				w.csel = C_LRD_VALID;
				w.target = S_TW0;
			end
			S_TX: begin
				w.seq_op = OP_BRANCH;
				w.csel = C_CMD_DEL;
				w.target = S_DT0;
			end
			S_IT2: begin
				w.lw_sel = LW_P_N;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_DT0: begin
				w.rd_sel = RA_P;
			end
			S_DT1: begin
				w.rm_ld = 1'b1;
				w.seq_op = OP_BRANCH;
				w.csel = C_PREV_NIL;
				w.target = S_DT2B;
			end
			S_DT2: begin
				w.lw_sel = LW_Q_NIL;
				w.seq_op = OP_GOTO;
				w.target = S_DT3;
			end
			S_DT2B: begin
				w.h_sel = H_NIL;
			end
			S_DT3: begin
				w.lw_sel = LW_P_FREE;
				w.f_sel = F_P;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_DH0: begin
				w.rd_sel = RA_HEAD;
				w.n_sel = N_HEAD;
			end
			S_DH1: begin
				w.h_sel = H_LRD;
				w.rm_ld = 1'b1;
				w.lw_sel = LW_N_FREE;
				w.f_sel = F_N;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_OVF: begin
				w.st_ld = 1'b1;
				w.st_code = ST_OVERFLOW;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_UND: begin
				w.st_ld = 1'b1;
				w.st_code = ST_UNDERFLOW;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_MIS: begin
				w.st_ld = 1'b1;
				w.st_code = ST_MISSING;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_NAF: begin
				w.st_ld = 1'b1;
				w.st_code = ST_NOTHING_AFTER;
				w.seq_op = OP_GOTO;
				w.target = S_DONE;
			end
			S_DONE: begin
				w.out_ld = 1'b1;
				w.seq_op = OP_WAIT;
				w.csel = C_OUT_BUSY;
				w.target = S_IDLE;
			end
			default: begin
				w.seq_op = OP_GOTO;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/ale_req_if.sv
// command channel of the array linked list engine
interface ale_req_if;
	logic valid;
	logic ready;
	logic [ale_pkg::CMD_W-1:0] command;
	logic signed [ale_pkg::VAL_W-1:0] item_value;
	logic signed [ale_pkg::VAL_W-1:0] reference_value;

	modport source(output valid, command, item_value, reference_value, input ready);
	modport sink(input valid, command, item_value, reference_value, output ready);
endinterface

// File: rtl/core/ale_rsp_if.sv
// result channel of the array linked list engine
interface ale_rsp_if;
	logic valid;
	logic ready;
	logic signed [ale_pkg::VAL_W-1:0] removed_value;
	logic [ale_pkg::ST_W-1:0] status;

	modport source(output valid, removed_value, status, input ready);
	modport sink(input valid, removed_value, status, output ready);
endinterface

// File: rtl/core/array_linked_list_engine.sv
// one item in flight: the engine takes no new item until the result of the last one has loaded
// search and tail walks take two microcode steps per node, one pool read each
// next item is taken in idle, in the cycle after the result loads
// a result not yet taken holds the program in its last step and stalls the input
// reset: list empty, every node on the free list, link valid bits cleared at once, ready low
// top level of the array linked list engine
module array_linked_list_engine (
	input logic clk,
	input logic arst_n,
	ale_req_if.sink req,
	ale_rsp_if.source rsp
);

	ale_pkg::ctl_t ctl;
	ale_pkg::cond_t cond;

	ale_useq u_useq (
		.clk(clk),
		.arst_n(arst_n),
		.cond(cond),
		.ctl(ctl)
	);

	ale_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.cond(cond),
		.req(req),
		.rsp(rsp)
	);

endmodule

// File: rtl/core/ale_useq.sv
// microcode sequencer: step counter, control store and jump logic
module ale_useq (
	input logic clk,
	input logic arst_n,
	input ale_pkg::cond_t cond,
	output ale_pkg::ctl_t ctl
);

	ale_pkg::upc_t upc_q;
	ale_pkg::upc_t upc_nxt;
	logic c;

	always_comb begin
		ctl = ale_pkg::ucode(upc_q);
	end

	always_comb begin
		case (ctl.csel)
			ale_pkg::C_NO_ACCEPT: c = !cond.accept;
			ale_pkg::C_FREE_NIL: c = cond.free_nil;
			ale_pkg::C_SEARCH_END: c = cond.search_end;
			ale_pkg::C_NO_MATCH: c = cond.no_match;
			ale_pkg::C_P_NIL: c = cond.p_nil;
			ale_pkg::C_TAIL_END: c = cond.tail_end;
			ale_pkg::C_LRD_VALID: c = cond.lrd_valid;
			ale_pkg::C_CMD_DEL: c = cond.cmd_del;
			ale_pkg::C_PREV_NIL: c = cond.prev_nil;
			ale_pkg::C_OUT_BUSY: c = cond.out_busy;
			default: c = 1'b0;
		endcase
	end

	always_comb begin
		case (ctl.seq_op)
			ale_pkg::OP_NEXT: upc_nxt = upc_q + ale_pkg::upc_t'(1);
			ale_pkg::OP_GOTO: upc_nxt = ctl.target;
			ale_pkg::OP_BRANCH: upc_nxt = c ? ctl.target : upc_q + ale_pkg::upc_t'(1);
			ale_pkg::OP_WAIT: upc_nxt = c ? upc_q : ctl.target;
			ale_pkg::OP_DISPATCH: upc_nxt = ale_pkg::dispatch(cond.cmd, cond.empty);
			default: upc_nxt = ale_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ale_pkg::S_IDLE;
		end else begin
			upc_q <= upc_nxt;
		end
	end

endmodule

// File: rtl/core/ale_dp.sv
// datapath: node pool memories, list pointers, walk registers and result register
`include "array_linked_list_engine_defines.svh"

module ale_dp (
	input logic clk,
	input logic arst_n,
	input ale_pkg::ctl_t ctl,
	output ale_pkg::cond_t cond,
	ale_req_if.sink req,
	ale_rsp_if.source rsp
);

	logic [ale_pkg::VAL_W-1:0] val_mem_q [ale_pkg::NODE_COUNT];
	ale_pkg::idx_t link_mem_q [ale_pkg::NODE_COUNT];
	logic [ale_pkg::NODE_COUNT-1:0] link_vld_q;

	ale_pkg::idx_t head_q;
	ale_pkg::idx_t free_q;
	ale_pkg::idx_t p_q;
	ale_pkg::idx_t prev_q;
	ale_pkg::idx_t node_q;
	ale_pkg::idx_t k_q;
	ale_pkg::idx_t lrd_q;
	logic [ale_pkg::VAL_W-1:0] vrd_q;

	logic [ale_pkg::CMD_W-1:0] cmd_q;
	logic [ale_pkg::VAL_W-1:0] item_q;
	logic [ale_pkg::VAL_W-1:0] ref_q;
	logic [ale_pkg::VAL_W-1:0] removed_q;
	logic [ale_pkg::ST_W-1:0] status_q;

	logic out_valid_q;
	logic [ale_pkg::VAL_W-1:0] out_removed_q;
	logic [ale_pkg::ST_W-1:0] out_status_q;

	logic in_rdy;
	logic acc;
	logic out_busy;
	logic out_load;
	ale_pkg::idx_t rd_idx;
	ale_pkg::addr_t rd_addr;
	logic rd_en;
	ale_pkg::idx_t wr_idx;
	ale_pkg::idx_t wr_data;
	ale_pkg::addr_t wr_addr;
	logic lw_en;
	logic vw_en;

	// no item is taken while reset is asserted
	assign in_rdy = ctl.in_rdy && arst_n;
	assign req.ready = in_rdy;
	assign acc = req.valid && in_rdy;
	assign out_busy = out_valid_q && !rsp.ready;
	assign out_load = ctl.out_ld && !out_busy;

	assign rsp.valid = out_valid_q;
	assign rsp.removed_value = out_removed_q;
	assign rsp.status = out_status_q;

	always_comb begin
		cond.accept = acc;
		cond.empty = !ale_pkg::is_valid(head_q);
		cond.cmd = cmd_q;
		cond.free_nil = !ale_pkg::is_valid(free_q);
		cond.search_end = (k_q == ale_pkg::WALK_MAX) || !ale_pkg::is_valid(p_q);
		cond.no_match = vrd_q != ref_q;
		cond.p_nil = !ale_pkg::is_valid(p_q);
		cond.tail_end = k_q == ale_pkg::TAIL_MAX;
		cond.lrd_valid = ale_pkg::is_valid(lrd_q);
		cond.cmd_del = (cmd_q == ale_pkg::CMD_DEL_AFTER) || (cmd_q == ale_pkg::CMD_DEL_TAIL);
		cond.prev_nil = !ale_pkg::is_valid(prev_q);
		cond.out_busy = out_busy;
	end

	// memory read port
	always_comb begin
		case (ctl.rd_sel)
			ale_pkg::RA_FREE: rd_idx = free_q;
			ale_pkg::RA_P: rd_idx = p_q;
			ale_pkg::RA_HEAD: rd_idx = head_q;
			default: rd_idx = ale_pkg::NIL;
		endcase
	end

	assign rd_en = ale_pkg::is_valid(rd_idx);
	assign rd_addr = rd_idx[ale_pkg::ADDR_W-1:0];

	// link write port
	always_comb begin
		case (ctl.lw_sel)
			ale_pkg::LW_N_HEAD: begin
				wr_idx = node_q;
				wr_data = head_q;
			end
			ale_pkg::LW_N_P: begin
				wr_idx = node_q;
				wr_data = p_q;
			end
			ale_pkg::LW_Q_N: begin
				wr_idx = prev_q;
				wr_data = node_q;
			end
			ale_pkg::LW_Q_LRD: begin
				wr_idx = prev_q;
				wr_data = lrd_q;
			end
			ale_pkg::LW_N_FREE: begin
				wr_idx = node_q;
				wr_data = free_q;
			end
			ale_pkg::LW_N_NIL: begin
				wr_idx = node_q;
				wr_data = ale_pkg::NIL;
			end
			ale_pkg::LW_P_N: begin
				wr_idx = p_q;
				wr_data = node_q;
			end
			ale_pkg::LW_Q_NIL: begin
				wr_idx = prev_q;
				wr_data = ale_pkg::NIL;
			end
			ale_pkg::LW_P_FREE: begin
				wr_idx = p_q;
				wr_data = free_q;
			end
			default: begin
				wr_idx = ale_pkg::NIL;
				wr_data = ale_pkg::NIL;
			end
		endcase
	end

	assign lw_en = ale_pkg::is_valid(wr_idx);
	assign wr_addr = wr_idx[ale_pkg::ADDR_W-1:0];
	assign vw_en = ctl.vw && ale_pkg::is_valid(node_q);

	// node pool; a link never written reads as its reset chain value
	always_ff @(posedge clk) begin
		if (rd_en) begin
			vrd_q <= val_mem_q[rd_addr];
			lrd_q <= link_vld_q[rd_addr] ? link_mem_q[rd_addr]
				: ale_pkg::idx_t'(rd_addr) + ale_pkg::idx_t'(1);
		end
		if (lw_en) begin
			link_mem_q[wr_addr] <= wr_data;
		end
		if (vw_en) begin
			val_mem_q[node_q[ale_pkg::ADDR_W-1:0]] <= item_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
			head_q <= ale_pkg::NIL;
			free_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (lw_en) begin
				link_vld_q[wr_addr] <= 1'b1;
			end
			case (ctl.h_sel)
				ale_pkg::H_N: head_q <= node_q;
				ale_pkg::H_LRD: head_q <= lrd_q;
				ale_pkg::H_NIL: head_q <= ale_pkg::NIL;
				default: head_q <= head_q;
			endcase
			case (ctl.f_sel)
				ale_pkg::F_LRD: free_q <= lrd_q;
				ale_pkg::F_N: free_q <= node_q;
				ale_pkg::F_P: free_q <= p_q;
				default: free_q <= free_q;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= req.command;
			item_q <= req.item_value;
			ref_q <= req.reference_value;
			p_q <= head_q;
			prev_q <= ale_pkg::NIL;
			k_q <= '0;
			removed_q <= '0;
			status_q <= ale_pkg::ST_OK;
		end else begin
			case (ctl.walk)
				ale_pkg::W_ADV: begin
					prev_q <= p_q;
					p_q <= lrd_q;
					k_q <= k_q + ale_pkg::idx_t'(1);
				end
				ale_pkg::W_STEP: begin
					if (ale_pkg::is_valid(lrd_q)) begin
						prev_q <= p_q;
						p_q <= lrd_q;
					end
					k_q <= k_q + ale_pkg::idx_t'(1);
				end
				default: begin
				end
			endcase
			if (ctl.rm_ld) begin
				removed_q <= vrd_q;
			end
			if (ctl.st_ld) begin
				status_q <= ctl.st_code;
			end
		end
		case (ctl.n_sel)
			ale_pkg::N_FREE: node_q <= free_q;
			ale_pkg::N_P: node_q <= p_q;
			ale_pkg::N_HEAD: node_q <= head_q;
			default: node_q <= node_q;
		endcase
		if (out_load) begin
			out_removed_q <= removed_q;
			out_status_q <= status_q;
		end
	end

	`ALE_ASSERT_IMP(a_free_not_head, clk, arst_n, ale_pkg::is_valid(free_q), free_q != head_q)
	`ALE_ASSERT_IMP(a_err_no_value, clk, arst_n, out_valid_q && (out_status_q != ale_pkg::ST_OK), out_removed_q == '0)
	`ALE_ASSERT_NXT(a_one_item, clk, arst_n, acc, !req.ready)

endmodule

// File: verif/testbench.sv
// self-checking testbench of the array linked list engine: predicts every result and compares
`timescale 1ns / 100ps

module testbench;
	import ale_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;
	localparam int RANDOM_ITEMS = 1525;
	localparam int IDLE_MAX = 12;
	localparam int SETTLE_CYCLES = 2 * NODE_COUNT + 10;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		logic [CMD_W-1:0] command;
		logic signed [VAL_W-1:0] item_value;
		logic signed [VAL_W-1:0] reference_value;
	} list_cmd_t;

	typedef struct {
		logic signed [VAL_W-1:0] removed_value;
		logic [ST_W-1:0] status;
	} list_ans_t;

	logic clk;
	logic arst_n;
	logic hold_rx;

	ale_req_if req_ch ();
	ale_rsp_if rsp_ch ();

	array_linked_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// shadow of the node pool
	logic [VAL_W-1:0] pool_val [NODE_COUNT];
	idx_t pool_link [NODE_COUNT];
	idx_t list_top;
	idx_t free_top;

	list_cmd_t commands_to_send[$];
	list_ans_t outcomes_due[$];
	list_cmd_t in_flight;
	int sent_count;
	int rx_count;
	int failures;
	int drv_gap;
	int rx_wait;
	logic offering;
	logic launch;

	function automatic logic in_pool(input idx_t i);
		return i < NIL;
	endfunction

	function automatic void reset_pool();
		for (int i = 0; i < NODE_COUNT; i++) begin
			pool_val[i] = '0;
			pool_link[i] = idx_t'(i + 1);
		end
		list_top = NIL;
		free_top = '0;
	endfunction

	function automatic idx_t take_node(input logic [VAL_W-1:0] v);
		idx_t n;
		n = free_top;
		if (!in_pool(n))
			return NIL;
		free_top = pool_link[n];
		pool_val[n] = v;
		pool_link[n] = NIL;
		return n;
	endfunction

	function automatic void give_node(input idx_t n);
		if (in_pool(n)) begin
			pool_link[n] = free_top;
			free_top = n;
		end
	endfunction

	function automatic idx_t find_ref(input logic [VAL_W-1:0] v);
		idx_t p;
		p = list_top;
		for (int k = 0; k < NODE_COUNT; k++) begin
			if (!in_pool(p))
				return NIL;
			if (pool_val[p] == v)
				return p;
			p = pool_link[p];
		end
		return NIL;
	endfunction

	function automatic idx_t find_tail(output idx_t prev);
		idx_t p;
		idx_t q;
		idx_t nx;
		p = list_top;
		q = NIL;
		for (int k = 1; k < NODE_COUNT; k++) begin
			nx = in_pool(p) ? pool_link[p] : NIL;
			if (!in_pool(nx))
				break;
			q = p;
			p = nx;
		end
		prev = q;
		return p;
	endfunction

	function automatic logic [ST_W-1:0] push_front(input logic [VAL_W-1:0] v);
		idx_t n;
		n = take_node(v);
		if (!in_pool(n))
			return ST_OVERFLOW;
		pool_link[n] = in_pool(list_top) ? list_top : NIL;
		list_top = n;
		return ST_OK;
	endfunction

	function automatic list_ans_t list_op_outcome(input list_cmd_t c);
		list_ans_t a;
		idx_t r;
		idx_t n;
		idx_t t;
		idx_t prev;
		logic was_empty;
		a.removed_value = '0;
		a.status = ST_OK;
		was_empty = !in_pool(list_top);
		case (c.command)
			CMD_INS_HEAD: begin
				a.status = push_front(c.item_value);
			end
			CMD_INS_AFTER: begin
				if (was_empty) begin
					a.status = push_front(c.item_value);
				end else begin
					r = find_ref(c.reference_value);
					if (!in_pool(r)) begin
						a.status = ST_MISSING;
					end else begin
						n = take_node(c.item_value);
						if (!in_pool(n)) begin
							a.status = ST_OVERFLOW;
						end else begin
							pool_link[n] = pool_link[r];
							pool_link[r] = n;
						end
					end
				end
			end
			CMD_INS_TAIL: begin
				if (was_empty) begin
					a.status = push_front(c.item_value);
				end else begin
					n = take_node(c.item_value);
					if (!in_pool(n)) begin
						a.status = ST_OVERFLOW;
					end else begin
						t = find_tail(prev);
						if (in_pool(t))
							pool_link[t] = n;
					end
				end
			end
			CMD_DEL_HEAD: begin
				if (was_empty) begin
					a.status = ST_UNDERFLOW;
				end else begin
					n = list_top;
					list_top = pool_link[n];
					a.removed_value = pool_val[n];
					give_node(n);
				end
			end
			CMD_DEL_AFTER: begin
				if (was_empty) begin
					a.status = ST_UNDERFLOW;
				end else begin
					r = find_ref(c.reference_value);
					if (!in_pool(r)) begin
						a.status = ST_MISSING;
					end else begin
						n = pool_link[r];
						if (!in_pool(n)) begin
							a.status = ST_NOTHING_AFTER;
						end else begin
							a.removed_value = pool_val[n];
							pool_link[r] = pool_link[n];
							give_node(n);
						end
					end
				end
			end
			CMD_DEL_TAIL: begin
				if (was_empty) begin
					a.status = ST_UNDERFLOW;
				end else begin
					t = find_tail(prev);
					if (in_pool(t)) begin
						a.removed_value = pool_val[t];
						if (in_pool(prev))
							pool_link[prev] = NIL;
						else
							list_top = NIL;
						give_node(t);
					end
				end
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	function automatic int draw_idle(input int n);
		// every fourth stretch runs with no idle cycles
		if ((n / 120) % 4 == 3)
			return 0;
		return $urandom_range(0, IDLE_MAX);
	endfunction

	function automatic logic [VAL_W-1:0] draw_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return $urandom_range(0, 7);
		endcase
	endfunction

	task automatic enqueue_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] item,
			input logic [VAL_W-1:0] key);
		list_cmd_t c;
		c.command = cmd;
		c.item_value = item;
		c.reference_value = key;
		commands_to_send.push_back(c);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		hold_rx = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = '0;
		req_ch.item_value = '0;
		req_ch.reference_value = '0;
		rsp_ch.ready = 1'b0;
		failures = 0;
		sent_count = 0;
		rx_count = 0;
		reset_pool();

		// deletes on an empty list
		enqueue_command(CMD_DEL_HEAD, 32'd9, 32'd9);
		enqueue_command(CMD_DEL_AFTER, 32'd9, 32'd0);
		enqueue_command(CMD_DEL_TAIL, 32'd9, 32'd0);
		// insert after on an empty list, then delete tail of one node
		enqueue_command(CMD_INS_AFTER, 32'h7fff_ffff, 32'h7fff_ffff);
		enqueue_command(CMD_DEL_TAIL, 32'd0, 32'd0);
		enqueue_command(CMD_INS_HEAD, 32'h8000_0000, 32'hffff_ffff);
		enqueue_command(CMD_INS_TAIL, 32'd0, 32'h8000_0000);
		enqueue_command(CMD_INS_TAIL, 32'hffff_ffff, 32'd0);
		enqueue_command(CMD_INS_AFTER, 32'd1, 32'd0);
		enqueue_command(CMD_INS_AFTER, 32'd7, 32'd12345);
		// reference is the tail
		enqueue_command(CMD_DEL_AFTER, 32'd0, 32'hffff_ffff);
		enqueue_command(CMD_DEL_AFTER, 32'd0, 32'd0);
		enqueue_command(CMD_DEL_HEAD, 32'd0, 32'd0);
		enqueue_command(CMD_UNUSED_A, 32'hdead_beef, 32'd0);
		enqueue_command(CMD_UNUSED_B, 32'h1234_5678, 32'hffff_ffff);
		for (int v = 2; v < 8; v++)
			enqueue_command(v[0] ? CMD_INS_TAIL : CMD_INS_HEAD, v, 32'd0);
		// full pool
		enqueue_command(CMD_INS_HEAD, 32'd8, 32'd0);
		enqueue_command(CMD_INS_TAIL, 32'd8, 32'd0);
		enqueue_command(CMD_INS_AFTER, 32'd8, 32'd99);
		enqueue_command(CMD_INS_AFTER, 32'd8, 32'd2);
		enqueue_command(CMD_DEL_TAIL, 32'd0, 32'd0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 2)
				enqueue_command($urandom_range(0, 1) ? CMD_UNUSED_B : CMD_UNUSED_A,
					draw_value(), draw_value());
			else
				enqueue_command(logic'($urandom_range(0, 5)) ?
					CMD_W'($urandom_range(0, 5)) : CMD_INS_HEAD,
					draw_value(), draw_value());
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (commands_to_send.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// receiver holds off for a long stretch while the sender keeps offering
	initial begin
		wait (rx_count >= HOLD_AFTER);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= '0;
			req_ch.item_value <= '0;
			req_ch.reference_value <= '0;
			drv_gap = 0;
		end else begin
			launch = 1'b0;
			offering = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				outcomes_due.push_back(list_op_outcome(in_flight));
				sent_count++;
				drv_gap = draw_idle(sent_count);
				offering = 1'b0;
			end
			if (!offering) begin
				if (drv_gap > 0) begin
					drv_gap--;
				end else if (commands_to_send.size() != 0) begin
					in_flight = commands_to_send.pop_front();
					launch = 1'b1;
				end
			end
			req_ch.valid <= offering || launch;
			if (launch) begin
				req_ch.command <= in_flight.command;
				req_ch.item_value <= in_flight.item_value;
				req_ch.reference_value <= in_flight.reference_value;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		list_ans_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (outcomes_due.size() == 0) begin
					$error("unexpected result: removed_value %0d status %0d",
						rsp_ch.removed_value, rsp_ch.status);
					failures++;
				end else begin
					want = outcomes_due.pop_front();
					if (rsp_ch.removed_value !== want.removed_value) begin
						$error("removed_value: expected %0d, actual %0d",
							want.removed_value, rsp_ch.removed_value);
						failures++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
						failures++;
					end
				end
				rx_count++;
				rx_wait = draw_idle(rx_count);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			rsp_ch.ready <= (rx_wait == 0) && !hold_rx;
		end
	end

endmodule
